// ===== hw/rtl/alm_pkg.sv =====
package alm_pkg;

  localparam int LEVEL_W  = 12;
  localparam int DECAY_W  = 16;
  localparam int BRIGHT_W = 8;
  localparam int HEIGHT_W = 15;
  localparam int FRAC_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int COLOR_W  = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;

  localparam int NUM_LEDS_DEF = 32;

  // rise filter weights, about 0.2 old and 0.8 new in 1/256 steps
  localparam int RISE_OLD = 51;
  localparam int RISE_NEW = 205;
  localparam int RISE_W   = 23;

  localparam logic [LEVEL_W-1:0]  GATE_LEVEL_RST = 12'd400;
  localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST  = 12'd2500;
  localparam logic [DECAY_W-1:0]  DECAY_STEP_RST = 16'd512;
  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 8'd100;

  localparam logic [1:0] REG_GATE_LEVEL = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL  = 2'd1;
  localparam logic [1:0] REG_DECAY_STEP = 2'd2;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0]  gate_level;
    logic [LEVEL_W-1:0]  max_level;
    logic [DECAY_W-1:0]  decay_step;
    logic [BRIGHT_W-1:0] brightness;
  } alm_cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic update;
    logic emit_start;
    logic emit_adv;
  } alm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic emit_last;
  } alm_sts_t;

endpackage

// ===== hw/rtl/alm_regs.sv =====
module alm_regs
  import alm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output alm_cfg_t          cfg
);

  alm_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_level <= GATE_LEVEL_RST;
      cfg_r.max_level  <= MAX_LEVEL_RST;
      cfg_r.decay_step <= DECAY_STEP_RST;
      cfg_r.brightness <= BRIGHTNESS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GATE_LEVEL: cfg_r.gate_level <= cfg_pwdata[LEVEL_W-1:0];
        REG_MAX_LEVEL:  cfg_r.max_level  <= cfg_pwdata[LEVEL_W-1:0];
        REG_DECAY_STEP: cfg_r.decay_step <= cfg_pwdata[DECAY_W-1:0];
        REG_BRIGHTNESS: cfg_r.brightness <= cfg_pwdata[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GATE_LEVEL: cfg_prdata = APB_DW'(cfg_r.gate_level);
      REG_MAX_LEVEL:  cfg_prdata = APB_DW'(cfg_r.max_level);
      REG_DECAY_STEP: cfg_prdata = APB_DW'(cfg_r.decay_step);
      REG_BRIGHTNESS: cfg_prdata = APB_DW'(cfg_r.brightness);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/alm_ctrl.sv =====
module alm_ctrl
  import alm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     out_free,
  input  alm_sts_t sts,
  output alm_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update     = 1'b1;
        cmd.emit_start = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_adv = out_free;
        if (out_free && sts.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/alm_dp.sv =====
module alm_dp
  import alm_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  alm_cfg_t           cfg,
  input  logic [LEVEL_W-1:0] level_sample,
  input  alm_cmd_t           cmd,
  output alm_sts_t           sts,
  input  logic               out_tready,
  output logic               out_valid,
  output logic [INDEX_W-1:0] out_led_index,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic               out_last
);

  localparam int QW   = $clog2(NUM_LEDS + 1);
  localparam int KW   = $clog2(QW);
  localparam int NUMW = LEVEL_W + QW;
  localparam int IW   = $clog2(NUM_LEDS);
  localparam int ZONE_GREEN  = NUM_LEDS / 3;
  localparam int ZONE_YELLOW = (2 * NUM_LEDS) / 3;

  // sample scaling and divider
  logic [LEVEL_W-1:0] s_clamp, diff, den_r;
  logic [NUMW-1:0]    num, rem_r, trial;
  logic [QW-1:0]      q_r, target;
  logic [KW-1:0]      k_r;
  logic               zero_r, zero_in, ge;

  // bar height
  logic [HEIGHT_W-1:0] h_r, h_nxt;
  logic [QW+FRAC_W-1:0] tfix;
  logic [RISE_W-1:0]   rise_sum;

  // emit
  logic [IW-1:0]      idx_r;
  logic [6:0]         lit;
  logic               is_lit;
  logic [COLOR_W-1:0] red_c, green_c;
  logic               out_valid_r, out_last_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic [COLOR_W-1:0] out_red_r, out_green_r;

  assign s_clamp = (level_sample > cfg.max_level) ? cfg.max_level : level_sample;
  assign diff    = s_clamp - cfg.gate_level;
  assign num     = NUMW'(diff) * NUMW'(NUM_LEDS);
  assign zero_in = (level_sample <= cfg.gate_level) || (cfg.max_level <= cfg.gate_level);

  assign trial = NUMW'(den_r) << k_r;
  assign ge    = (rem_r >= trial);

  // restoring divide, one quotient bit per cycle from the top
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= num;
      den_r  <= cfg.max_level - cfg.gate_level;
      zero_r <= zero_in;
      q_r    <= '0;
      k_r    <= KW'(QW - 1);
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - trial;
      q_r[k_r] <= ge;
      k_r      <= k_r - 1'b1;
    end
  end

  assign sts.div_done = (k_r == '0);

  assign target   = zero_r ? '0 : q_r;
  assign tfix     = {target, {FRAC_W{1'b0}}};
  assign rise_sum = RISE_W'(RISE_OLD) * RISE_W'(h_r) + RISE_W'(RISE_NEW) * RISE_W'(tfix);

  always_comb begin
    if (HEIGHT_W'(tfix) > h_r) begin
      h_nxt = rise_sum[RISE_W-1:FRAC_W];
    end else if ({1'b0, h_r} > cfg.decay_step) begin
      h_nxt = h_r - cfg.decay_step[HEIGHT_W-1:0];
    end else begin
      h_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else if (cmd.update) begin
      h_r <= h_nxt;
    end
  end

  // idx never reaches NUM_LEDS, so no clamp of the integer height is needed
  assign lit    = h_r[HEIGHT_W-1:FRAC_W];
  assign is_lit = (7'(idx_r) < lit);

  always_comb begin
    red_c   = '0;
    green_c = '0;
    if (is_lit) begin
      if (idx_r < IW'(ZONE_GREEN)) begin
        green_c = cfg.brightness;
      end else if (idx_r < IW'(ZONE_YELLOW)) begin
        red_c   = cfg.brightness;
        green_c = cfg.brightness;
      end else begin
        red_c = cfg.brightness;
      end
    end
  end

  assign sts.emit_last = (idx_r == IW'(NUM_LEDS - 1));

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      idx_r <= '0;
    end else if (cmd.emit_adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_adv) begin
      out_idx_r   <= INDEX_W'(idx_r);
      out_red_r   <= red_c;
      out_green_r <= green_c;
      out_last_r  <= sts.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = out_idx_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_last      = out_last_r;

endmodule

// ===== hw/rtl/audio_level_bar_meter_core.sv =====
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | in_tdata[11:0] level_sample
// out_    | out | out_tvalid/tready   | tdata: led_index, red, green, blue; tlast last_led
// cfg_    | in  | APB, pready tied 1  | gate_level, max_level, decay_step, brightness
//
// One sample at a time: accept, a restoring divide, a height update, then
// NUM_LEDS output items at one per cycle while out_tready does not stall.
// The block has a single restoring divider and a one-item output register.
// A new sample is taken while the final item still waits in the output register.
// Synchronous active-low reset clears the height and restores register defaults.
// A stalled out_tready holds the current item and pauses the LED sweep.
module audio_level_bar_meter_core
  import alm_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,    // [11:0] level_sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // [5:0] led_index, [13:6] red, [21:14] green,
                                         // [29:22] blue
  output logic              out_tlast,   // last_led
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  alm_cfg_t           cfg;
  alm_cmd_t           cmd;
  alm_sts_t           sts;
  logic               out_free;
  logic [INDEX_W-1:0] led_index;
  logic [COLOR_W-1:0] red, green;

  alm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  alm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd)
  );

  alm_dp #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .level_sample  (in_tdata[LEVEL_W-1:0]),
    .cmd           (cmd),
    .sts           (sts),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_led_index (led_index),
    .out_red       (red),
    .out_green     (green),
    .out_last      (out_tlast)
  );

  assign out_free  = !out_tvalid || out_tready;
  assign out_tdata = {2'b00, {COLOR_W{1'b0}}, green, red, led_index};

endmodule

// ===== hw/rtl/alm_checker.sv =====
module alm_checker
  import alm_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  localparam int ZONE_YELLOW = (2 * NUM_LEDS) / 3;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while a request is in work");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[5:0] == 6'(NUM_LEDS - 1))
    else $error("tlast on an LED that is not the last");

  a_red_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:6] != 8'd0 && out_tdata[21:14] == 8'd0
      |-> out_tdata[5:0] >= 6'(ZONE_YELLOW))
    else $error("pure red LED below the red zone");

endmodule

bind audio_level_bar_meter_core alm_checker #(
  .NUM_LEDS (NUM_LEDS)
) u_alm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/audio_level_bar_meter_checker.sv =====
module audio_level_bar_meter_checker
  import alm_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [31:0]       out_tdata,
  input  logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  input  logic [APB_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                leds_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_led;
  } led_item_t;

  led_item_t           pending_leds[$];
  alm_cfg_t            meter_cfg;
  logic [HEIGHT_W-1:0] bar_height;

  function automatic int unsigned bar_target(logic [LEVEL_W-1:0] sample);
    int unsigned lvl;
    int unsigned floor_lvl;
    int unsigned top_lvl;
    lvl = sample;
    floor_lvl = meter_cfg.gate_level;
    top_lvl = meter_cfg.max_level;
    if (lvl <= floor_lvl || top_lvl <= floor_lvl) return 0;
    if (lvl > top_lvl) lvl = top_lvl;
    return ((lvl - floor_lvl) * NUM_LEDS) / (top_lvl - floor_lvl);
  endfunction

  // updates the bar height and queues one colour item per LED
  function automatic void predict_led_frame(logic [LEVEL_W-1:0] sample);
    int unsigned tfix;
    int unsigned h;
    int unsigned lit;
    led_item_t   e;
    tfix = bar_target(sample) << FRAC_W;
    h = bar_height;
    if (tfix > h) h = (RISE_OLD * h + RISE_NEW * tfix) >> FRAC_W;
    else if (h > meter_cfg.decay_step) h = h - meter_cfg.decay_step;
    else h = 0;
    bar_height = h[HEIGHT_W-1:0];
    lit = bar_height >> FRAC_W;
    if (lit > NUM_LEDS) lit = NUM_LEDS;
    for (int i = 0; i < NUM_LEDS; i++) begin
      e.led_index = i[INDEX_W-1:0];
      e.red = '0;
      e.green = '0;
      e.blue = '0;
      e.last_led = (i == NUM_LEDS - 1);
      if (i < lit) begin
        if (i < NUM_LEDS / 3) begin
          e.green = meter_cfg.brightness;
        end else if (i < (2 * NUM_LEDS) / 3) begin
          e.red = meter_cfg.brightness;
          e.green = meter_cfg.brightness;
        end else begin
          e.red = meter_cfg.brightness;
        end
      end
      pending_leds.push_back(e);
    end
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    led_item_t         want;
    logic [APB_DW-1:0] rd_want;
    if (!rst_n) begin
      meter_cfg = '{GATE_LEVEL_RST, MAX_LEVEL_RST, DECAY_STEP_RST, BRIGHTNESS_RST};
      bar_height = '0;
      pending_leds.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[APB_AW-1:2])
            REG_GATE_LEVEL: meter_cfg.gate_level = cfg_pwdata[LEVEL_W-1:0];
            REG_MAX_LEVEL:  meter_cfg.max_level = cfg_pwdata[LEVEL_W-1:0];
            REG_DECAY_STEP: meter_cfg.decay_step = cfg_pwdata[DECAY_W-1:0];
            REG_BRIGHTNESS: meter_cfg.brightness = cfg_pwdata[BRIGHT_W-1:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[APB_AW-1:2])
            REG_GATE_LEVEL: rd_want = APB_DW'(meter_cfg.gate_level);
            REG_MAX_LEVEL:  rd_want = APB_DW'(meter_cfg.max_level);
            REG_DECAY_STEP: rd_want = APB_DW'(meter_cfg.decay_step);
            default:        rd_want = APB_DW'(meter_cfg.brightness);
          endcase
          check_field("prdata", rd_want, cfg_prdata);
        end
      end
      // drain before taking a new sample so an early result cannot match a fresh frame
      if (out_tvalid && out_tready) begin
        if (pending_leds.size() == 0) begin
          $error("LED item with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = pending_leds.pop_front();
          check_field("led_index", want.led_index, out_tdata[5:0]);
          check_field("red", want.red, out_tdata[13:6]);
          check_field("green", want.green, out_tdata[21:14]);
          check_field("blue", want.blue, out_tdata[29:22]);
          check_field("last_led", want.last_led, out_tlast);
        end
      end
      if (in_tvalid && in_tready) predict_led_frame(in_tdata[LEVEL_W-1:0]);
    end
    leds_due = pending_leds.size();
  end

endmodule

// ===== tb/sv/audio_level_bar_meter_core_test.sv =====
module audio_level_bar_meter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import alm_pkg::*;

  localparam int NUM_LEDS         = 32;
  localparam int SETTLE_CYCLES    = 50;
  localparam int QUIET_LIMIT      = 2000;
  localparam int LEVELS_PER_PHASE = 36;
  localparam int NUM_PHASES       = 7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    alm_cfg_t   cfg;
    idle_mode_t mode;
  } meter_phase_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;     // [11:0] level_sample
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;         // [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue
  logic              out_tlast;         // last_led
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int           mismatch_count;
  int           leds_due;
  int           quiet_cycles = 0;
  int           levels_sent = 0;
  int           leds_seen = 0;
  idle_mode_t   idle_mode = IDLE_NONE;
  alm_cfg_t     cur_cfg;
  meter_phase_t phases[NUM_PHASES];
  logic [LEVEL_W-1:0] directed_levels[$];

  audio_level_bar_meter_core #(.NUM_LEDS(NUM_LEDS)) dut (.*);

  audio_level_bar_meter_checker #(.NUM_LEDS(NUM_LEDS)) checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    int unsigned stall_pct;
    case (idle_mode)
      IDLE_RECEIVER: stall_pct = 54;
      IDLE_BOTH:     stall_pct = 33;
      default:       stall_pct = 0;
    endcase
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog: cycles in which no request moves anywhere
  always @(posedge clk) begin
    if (out_tvalid && out_tready) leds_seen <= leds_seen + 1;
    if (!rst_n || cfg_psel || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d LED items pending", quiet_cycles,
               leds_due);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [APB_DW-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic program_meter(input alm_cfg_t c);
    apb_access(1'b1, REG_GATE_LEVEL, APB_DW'(c.gate_level));
    apb_access(1'b1, REG_MAX_LEVEL, APB_DW'(c.max_level));
    apb_access(1'b1, REG_DECAY_STEP, APB_DW'(c.decay_step));
    apb_access(1'b1, REG_BRIGHTNESS, APB_DW'(c.brightness));
    apb_access(1'b0, REG_GATE_LEVEL, '0);
    apb_access(1'b0, REG_MAX_LEVEL, '0);
    apb_access(1'b0, REG_DECAY_STEP, '0);
    apb_access(1'b0, REG_BRIGHTNESS, '0);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cur_cfg = c;
  endtask

  // in_tvalid stays up between back-to-back requests; it drops only for a gap or a drain
  task automatic send_level(input logic [LEVEL_W-1:0] lvl);
    int unsigned gap_pct;
    case (idle_mode)
      IDLE_SENDER: gap_pct = 54;
      IDLE_BOTH:   gap_pct = 33;
      default:     gap_pct = 0;
    endcase
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 16'($urandom_range(0, 4095));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, lvl};
    do @(posedge clk); while (!in_tready);
    levels_sent++;
  endtask

  task automatic drain_frames();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (leds_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // levels inside the active scale or over the full range, some at its edges, some silence for decay
  function automatic logic [LEVEL_W-1:0] pick_level();
    int unsigned floor_lvl;
    int unsigned top_lvl;
    int unsigned kind;
    int          v;
    floor_lvl = cur_cfg.gate_level;
    top_lvl = cur_cfg.max_level;
    kind = $urandom_range(0, 9);
    if (kind < 3 || (kind < 7 && top_lvl <= floor_lvl)) v = $urandom_range(0, 4095);
    else if (kind < 7) v = $urandom_range(floor_lvl + 1, top_lvl);
    else if (kind == 7) v = int'(floor_lvl) + 2 - int'($urandom_range(0, 4));
    else if (kind == 8) v = int'(top_lvl) + 2 - int'($urandom_range(0, 4));
    else v = 0;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[LEVEL_W-1:0];
  endfunction

  initial begin
    cur_cfg = '{GATE_LEVEL_RST, MAX_LEVEL_RST, DECAY_STEP_RST, BRIGHTNESS_RST};
    phases[0] = '{'{12'd0, 12'd4095, 16'd0, 8'd255}, IDLE_SENDER};
    phases[1] = '{'{12'd4095, 12'd4095, 16'd65535, 8'd1}, IDLE_RECEIVER};
    phases[2] = '{'{12'd1000, 12'd200, 16'd300, 8'd128}, IDLE_BOTH};
    phases[3] = '{'{12'd100, 12'd3000, 16'd1, 8'd0}, IDLE_NONE};
    phases[4] = '{'{12'd0, 12'd0, 16'd65535, 8'd255}, IDLE_SENDER};
    phases[5] = '{'{12'd2000, 12'd2100, 16'd2048, 8'd200}, IDLE_RECEIVER};
    phases[6] = '{'{12'd400, 12'd2500, 16'd512, 8'd100}, IDLE_BOTH};
    // reset settings: full rise, decay, floor and ceiling edges, bit patterns
    directed_levels = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0,
                        12'd0, 12'd400, 12'd401, 12'd2499, 12'd2500, 12'd2501, 12'hAAA,
                        12'h555, 12'd1450, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd1000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_levels[k]) send_level(directed_levels[k]);
    drain_frames();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_mode <= phases[p].mode;
      program_meter(phases[p].cfg);
      repeat (LEVELS_PER_PHASE) send_level(pick_level());
      drain_frames();
    end

    $display("Sent %0d level samples, checked %0d LED items over %0d register settings,",
             levels_sent, leds_seen, NUM_PHASES + 1);
    $display("with empty scales, clamped levels, zero and full decay, and random stalls.");
    if (mismatch_count == 0 && leds_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/alm_pkg.sv
hw/rtl/alm_regs.sv
hw/rtl/alm_ctrl.sv
hw/rtl/alm_dp.sv
hw/rtl/audio_level_bar_meter_core.sv
hw/rtl/alm_checker.sv
tb/sv/audio_level_bar_meter_checker.sv
tb/sv/audio_level_bar_meter_core_test.sv
